@@ src/psw_pkg.sv @@
// psw_pkg: shared types, codes and helpers for the pausable stopwatch timer
// no dependencies; used by the channel interfaces and the core

package psw_pkg;

  // time arithmetic width, wraps modulo 2^TIME_WIDTH
  localparam int unsigned TIME_WIDTH = 32;

  typedef logic [TIME_WIDTH-1:0] time_t;

  // command codes
  typedef enum logic [2:0] {
    OP_QUERY       = 3'd0,
    OP_START       = 3'd1,
    OP_STOP        = 3'd2,
    OP_PAUSE       = 3'd3,
    OP_RESTART     = 3'd4,
    OP_CHANGE_PER  = 3'd5,
    OP_SET_PERIOD  = 3'd6,
    OP_SET_ELAPSED = 3'd7
  } op_t;

  // run mode, one-hot
  typedef enum logic [2:0] {
    MODE_STOPPED  = 3'b001,
    MODE_COUNTING = 3'b010,
    MODE_PAUSED   = 3'b100
  } mode_t;

  // run_state codes on the result channel
  localparam logic [1:0] RS_STOPPED  = 2'd0;
  localparam logic [1:0] RS_COUNTING = 2'd1;
  localparam logic [1:0] RS_PAUSED   = 2'd2;

  // status codes
  localparam logic ST_ACCEPTED = 1'b0;
  localparam logic ST_REFUSED  = 1'b1;

  // command item
  typedef struct packed {
    logic [2:0] operation;
    time_t      timestamp;
    time_t      value;
  } cmd_t;

  // result item
  typedef struct packed {
    logic       status;
    logic [1:0] run_state;
    time_t      elapsed_now;
    time_t      remaining_now;
    logic       reached;
    time_t      period_now;
  } res_t;

  // one-hot mode to run_state code
  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    c = RS_STOPPED;
    case (m)
      MODE_COUNTING: c = RS_COUNTING;
      MODE_PAUSED:   c = RS_PAUSED;
      default:       c = RS_STOPPED;
    endcase
    return c;
  endfunction

endpackage

@@ src/psw_if.sv @@
// psw_if: valid/ready channel interfaces for commands and results
// depends on psw_pkg

interface psw_cmd_if import psw_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psw_res_if import psw_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/pausable_stopwatch_timer_core.sv @@
// pausable_stopwatch_timer_core: command register, stopwatch update and result register
// depends on psw_pkg and the channel interfaces in psw_if.sv
//
// Stopwatch driven by timestamped commands. A command is taken into an input register,
// then, once the result register is free or being emptied, it updates the mode, start
// stamp, accumulated time and period and produces one result, which sits in the output
// register until transferred. One command per cycle is sustained while results are
// taken. The input and result registers sit around a single subtract/add/compare pass.
// The input stalls only while both registers hold a command and the result is not
// taken. Elapsed and remaining times are taken at the command's timestamp, after the
// command has acted, and wrap modulo 2^32.

module pausable_stopwatch_timer_core
  import psw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  psw_cmd_if.sink   in_cmd,
  psw_res_if.source out_res
);

  // pipeline control
  logic  cmd_vld_r;
  cmd_t  cmd_r;
  logic  res_vld_r;
  res_t  res_r;
  logic  adv;

  // stopwatch state
  mode_t mode_r,   mode_nxt;
  time_t start_r,  start_nxt;
  time_t acc_r,    acc_nxt;
  time_t period_r, period_nxt;

  // evaluation
  logic  ok;
  logic  restarted;
  time_t span_old;
  time_t sum_old;
  time_t span_now;
  time_t el;
  time_t rem;
  time_t gap;
  logic  hit;
  op_t   op;

  assign adv          = !res_vld_r || out_res.ready;
  assign in_cmd.ready = !cmd_vld_r || adv;
  assign out_res.valid = res_vld_r;
  assign out_res.data  = res_r;

  // command register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else if (in_cmd.ready) begin
      cmd_vld_r <= in_cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_cmd.valid && in_cmd.ready) begin
      cmd_r <= in_cmd.data;
    end
  end

  // time since the stored start stamp
  assign op       = op_t'(cmd_r.operation);
  assign span_old = cmd_r.timestamp - start_r;
  assign sum_old  = acc_r + span_old;

  // command decode and state update
  always_comb begin
    mode_nxt   = mode_r;
    start_nxt  = start_r;
    acc_nxt    = acc_r;
    period_nxt = period_r;
    ok         = 1'b1;
    restarted  = 1'b0;
    unique case (op)
      OP_QUERY: begin
      end
      OP_START: begin
        if (mode_r == MODE_COUNTING) begin
          ok = 1'b0;
        end else begin
          start_nxt = cmd_r.timestamp;
          mode_nxt  = MODE_COUNTING;
          restarted = 1'b1;
        end
      end
      OP_STOP: begin
        start_nxt = '0;
        acc_nxt   = '0;
        mode_nxt  = MODE_STOPPED;
      end
      OP_PAUSE: begin
        if (mode_r == MODE_COUNTING) begin
          mode_nxt = MODE_PAUSED;
          acc_nxt  = sum_old;
        end else begin
          ok = 1'b0;
        end
      end
      OP_RESTART: begin
        start_nxt = cmd_r.timestamp;
        acc_nxt   = '0;
        mode_nxt  = MODE_COUNTING;
        restarted = 1'b1;
      end
      OP_CHANGE_PER: begin
        period_nxt = cmd_r.value;
        start_nxt  = cmd_r.timestamp;
        acc_nxt    = '0;
        mode_nxt   = MODE_COUNTING;
        restarted  = 1'b1;
      end
      OP_SET_PERIOD: begin
        if (mode_r == MODE_STOPPED) begin
          period_nxt = cmd_r.value;
        end else begin
          ok = 1'b0;
        end
      end
      OP_SET_ELAPSED: begin
        if (mode_r == MODE_STOPPED) begin
          acc_nxt = cmd_r.value;
        end else begin
          ok = 1'b0;
        end
      end
    endcase
  end

  // view at the command's timestamp; a fresh start has zero span
  assign span_now = restarted ? '0 : span_old;
  assign el       = (mode_nxt == MODE_COUNTING && !restarted) ? sum_old : acc_nxt;
  assign rem      = (el < period_nxt) ? (period_nxt - el) : '0;
  assign gap      = period_nxt - acc_nxt;

  // period reached flag
  always_comb begin
    hit = 1'b0;
    unique case (mode_nxt)
      MODE_PAUSED:   hit = (acc_nxt >= period_nxt);
      MODE_COUNTING: hit = (period_nxt > acc_nxt) ? (span_now >= gap) : 1'b1;
      default:       hit = 1'b0;
    endcase
  end

  // state registers, updated once per command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_STOPPED;
      start_r  <= '0;
      acc_r    <= '0;
      period_r <= '0;
    end else if (cmd_vld_r && adv) begin
      mode_r   <= mode_nxt;
      start_r  <= start_nxt;
      acc_r    <= acc_nxt;
      period_r <= period_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (adv) begin
      res_vld_r <= cmd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_vld_r && adv) begin
      res_r.status        <= ok ? ST_ACCEPTED : ST_REFUSED;
      res_r.run_state     <= mode_code(mode_nxt);
      res_r.elapsed_now   <= el;
      res_r.remaining_now <= rem;
      res_r.reached       <= hit;
      res_r.period_now    <= period_nxt;
    end
  end

  // a stop transfer leaves the stopwatch cleared
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_vld_r && adv && op == OP_STOP) |=> (mode_r == MODE_STOPPED && acc_r == '0))
    else $error("stop did not clear the stopwatch");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_cmd.ready |-> (res_vld_r && !out_res.ready && cmd_vld_r))
    else $error("input stalled without a held result");

  // when paused, reached goes with zero remaining time
  a_paused_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && res_r.run_state == RS_PAUSED) |->
      (res_r.reached == (res_r.remaining_now == '0)))
    else $error("paused reached flag disagrees with remaining time");

  // a stopped result never reports reached
  a_stopped_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && res_r.run_state == RS_STOPPED) |-> !res_r.reached)
    else $error("reached set while stopped");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking testbench for pausable_stopwatch_timer_core
// depends on psw_pkg and the channel interfaces in psw_if.sv; drives timestamped commands
// and compares every result with an in-bench model of the stopwatch or a directed expected result

module tb_top;
  import psw_pkg::*;

  // one directed stimulus row; want is used only when typed is set
  typedef struct {
    cmd_t cmd;
    bit   typed;
    res_t want;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  psw_cmd_if in_cmd ();
  psw_res_if out_res ();

  pausable_stopwatch_timer_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (in_cmd),
    .out_res (out_res)
  );

  // stopwatch model state
  logic [1:0] sw_mode;
  time_t      sw_start;
  time_t      sw_accum;
  time_t      sw_period;

  res_t     expected_results[$];
  cmd_row_t directed_rows[$];
  time_t    now_stamp;
  int       mismatches = 0;
  int       results_seen = 0;
  int       tx_idle_pct = 22;
  int       rx_idle_pct = 49;
  int       hold_left = 0;
  bit       held_once = 1'b0;

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // advance the stopwatch model by one command and return the view after it
  function automatic res_t stopwatch_predict(input cmd_t c);
    res_t  r;
    logic  ok;
    time_t el;
    time_t run_span;
    ok = 1'b1;
    case (op_t'(c.operation))
      OP_START: begin
        if (sw_mode == RS_COUNTING) begin
          ok = 1'b0;
        end else begin
          sw_start = c.timestamp;
          sw_mode  = RS_COUNTING;
        end
      end
      OP_STOP: begin
        sw_start = '0;
        sw_accum = '0;
        sw_mode  = RS_STOPPED;
      end
      OP_PAUSE: begin
        if (sw_mode == RS_COUNTING) begin
          sw_mode  = RS_PAUSED;
          sw_accum = sw_accum + (c.timestamp - sw_start);
        end else begin
          ok = 1'b0;
        end
      end
      OP_RESTART, OP_CHANGE_PER: begin
        if (op_t'(c.operation) == OP_CHANGE_PER) sw_period = c.value;
        sw_accum = '0;
        sw_start = c.timestamp;
        sw_mode  = RS_COUNTING;
      end
      OP_SET_PERIOD: begin
        if (sw_mode == RS_STOPPED) sw_period = c.value;
        else ok = 1'b0;
      end
      OP_SET_ELAPSED: begin
        if (sw_mode == RS_STOPPED) sw_accum = c.value;
        else ok = 1'b0;
      end
      default: ;
    endcase

    run_span = c.timestamp - sw_start;
    el = (sw_mode == RS_COUNTING) ? sw_accum + run_span : sw_accum;
    r.status        = ok ? ST_ACCEPTED : ST_REFUSED;
    r.run_state     = sw_mode;
    r.elapsed_now   = el;
    r.remaining_now = (el < sw_period) ? sw_period - el : '0;
    r.period_now    = sw_period;
    if (sw_mode == RS_STOPPED) r.reached = 1'b0;
    else if (sw_mode == RS_PAUSED) r.reached = (sw_accum >= sw_period);
    else if (sw_period > sw_accum) r.reached = (run_span >= sw_period - sw_accum);
    else r.reached = 1'b1;
    return r;
  endfunction

  function automatic cmd_row_t row(input op_t op, input time_t ts, input time_t val,
                                   input bit typed = 1'b0, input res_t want = '0);
    cmd_row_t s;
    s.cmd.operation = op;
    s.cmd.timestamp = ts;
    s.cmd.value     = val;
    s.typed         = typed;
    s.want          = want;
    return s;
  endfunction

  // random command: weighted operations, mostly a slowly advancing clock
  function automatic cmd_t next_random_cmd();
    cmd_t c;
    int   r;
    r = $urandom_range(99);
    if (r < 22) c.operation = OP_QUERY;
    else if (r < 37) c.operation = OP_START;
    else if (r < 45) c.operation = OP_STOP;
    else if (r < 58) c.operation = OP_PAUSE;
    else if (r < 66) c.operation = OP_RESTART;
    else if (r < 76) c.operation = OP_CHANGE_PER;
    else if (r < 88) c.operation = OP_SET_PERIOD;
    else c.operation = OP_SET_ELAPSED;

    case ($urandom_range(19))
      0:       now_stamp = $urandom;
      1:       now_stamp = 32'hFFFF_FFC0 + $urandom_range(0, 63);
      default: now_stamp = now_stamp + $urandom_range(0, 48);
    endcase
    c.timestamp = now_stamp;

    case ($urandom_range(9))
      0:       c.value = $urandom;
      1:       c.value = '1;
      2:       c.value = '0;
      default: c.value = $urandom_range(0, 160);
    endcase
    return c;
  endfunction

  // offer one command, wait for its transfer, then queue what it should return
  task automatic send_cmd(input cmd_t c, input bit typed, input res_t want);
    res_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_cmd.valid <= 1'b0;
      @(posedge clk);
    end
    in_cmd.valid <= 1'b1;
    in_cmd.data  <= c;
    do @(posedge clk); while (!in_cmd.ready);
    pred = stopwatch_predict(c);
    expected_results.push_back(typed ? want : pred);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random back-pressure plus one long hold-off late in the run
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_res.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!held_once && results_seen >= 450) begin
      held_once     <= 1'b1;
      hold_left     <= 80;
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker: each transfer against the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $display("%0t ns unexpected result: expected none, actual %h", $time, out_res.data);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        compare_field("status", 32'(want.status), 32'(out_res.data.status));
        compare_field("run_state", 32'(want.run_state), 32'(out_res.data.run_state));
        compare_field("elapsed_now", want.elapsed_now, out_res.data.elapsed_now);
        compare_field("remaining_now", want.remaining_now, out_res.data.remaining_now);
        compare_field("reached", 32'(want.reached), 32'(out_res.data.reached));
        compare_field("period_now", want.period_now, out_res.data.period_now);
      end
    end
  end

  // stimulus and end of run
  initial begin
    in_cmd.valid  = 1'b0;
    in_cmd.data   = '0;
    out_res.ready = 1'b0;
    sw_mode       = RS_STOPPED;
    sw_start      = '0;
    sw_accum      = '0;
    sw_period     = '0;
    now_stamp     = '0;

    // after reset, extremes, refusals in every mode, wrap of the time difference
    directed_rows.push_back(row(OP_QUERY, 32'h0, 32'h0, 1'b1,
      res_t'{ST_ACCEPTED, RS_STOPPED, 32'h0, 32'h0, 1'b0, 32'h0}));
    directed_rows.push_back(row(OP_PAUSE, 32'h1, 32'h0, 1'b1,
      res_t'{ST_REFUSED, RS_STOPPED, 32'h0, 32'h0, 1'b0, 32'h0}));
    directed_rows.push_back(row(OP_SET_PERIOD, 32'h2, 32'hFFFF_FFFF, 1'b1,
      res_t'{ST_ACCEPTED, RS_STOPPED, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF}));
    directed_rows.push_back(row(OP_SET_ELAPSED, 32'h3, 32'hFFFF_FFFF, 1'b1,
      res_t'{ST_ACCEPTED, RS_STOPPED, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'hFFFF_FFFF}));
    directed_rows.push_back(row(OP_START, 32'hFFFF_FFFF, 32'h0));
    directed_rows.push_back(row(OP_START, 32'h0, 32'h0));
    directed_rows.push_back(row(OP_QUERY, 32'h10, 32'h0));
    directed_rows.push_back(row(OP_PAUSE, 32'h20, 32'h0));
    directed_rows.push_back(row(OP_PAUSE, 32'h30, 32'h0));
    directed_rows.push_back(row(OP_SET_PERIOD, 32'h31, 32'h5));
    directed_rows.push_back(row(OP_SET_ELAPSED, 32'h32, 32'h6));
    directed_rows.push_back(row(OP_START, 32'h100, 32'h0));
    directed_rows.push_back(row(OP_RESTART, 32'h200, 32'h0));
    directed_rows.push_back(row(OP_CHANGE_PER, 32'h300, 32'h0));
    directed_rows.push_back(row(OP_CHANGE_PER, 32'hFFFF_FFF0, 32'hFFFF_FFFF));
    directed_rows.push_back(row(OP_QUERY, 32'hF, 32'h0));
    directed_rows.push_back(row(OP_SET_ELAPSED, 32'h16, 32'h1));
    directed_rows.push_back(row(OP_SET_PERIOD, 32'h17, 32'h1));
    directed_rows.push_back(row(OP_STOP, 32'h18, 32'h0, 1'b1,
      res_t'{ST_ACCEPTED, RS_STOPPED, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF}));
    directed_rows.push_back(row(OP_SET_PERIOD, 32'h19, 32'h0, 1'b1,
      res_t'{ST_ACCEPTED, RS_STOPPED, 32'h0, 32'h0, 1'b0, 32'h0}));
    directed_rows.push_back(row(OP_SET_ELAPSED, 32'h20, 32'h0, 1'b1,
      res_t'{ST_ACCEPTED, RS_STOPPED, 32'h0, 32'h0, 1'b0, 32'h0}));
    directed_rows.push_back(row(OP_RESTART, 32'hAAAA_AAAA, 32'h5555_5555));
    directed_rows.push_back(row(OP_QUERY, 32'h5555_5555, 32'hAAAA_AAAA));
    directed_rows.push_back(row(OP_STOP, 32'h0, 32'h0));
    directed_rows.push_back(row(OP_SET_PERIOD, 32'h0, 32'h40));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

    // random commands in three idle phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 22; rx_idle_pct = 49; end
        1: begin tx_idle_pct = 49; rx_idle_pct = 22; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      repeat (200) send_cmd(next_random_cmd(), 1'b0, '0);
    end
    in_cmd.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #200000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
